// ----- hw/rtl/tfmi_pkg.sv -----
// Shared types, constants and arithmetic helpers for the trilinear field map interpolator.
`default_nettype none
package tfmi_pkg;

	localparam int STORE_DEPTH = 32768;
	localparam int ADDR_W      = 15;
	localparam int SAMPLE_W    = 24;
	localparam int POS_W       = 32;
	localparam int FRAC_W      = 16;
	localparam int CELL_W      = 24;
	localparam int SCALE_W     = 24;
	localparam int OUT_W       = 32;
	localparam int AXES        = 3;
	localparam int CORNERS     = 8;
	localparam int RD_COPIES   = 4;
	localparam int QDEPTH      = 4;
	localparam int CNT_W       = $clog2(QDEPTH + 1);
	localparam int GRID_DEF    = 32;
	localparam int ACC_W       = 41;
	localparam int LERP_W      = 59;
	localparam int PROD_W      = 66;

	typedef enum logic [2:0] {
		REG_ORIGIN_X   = 3'd0,
		REG_ORIGIN_Y   = 3'd1,
		REG_ORIGIN_Z   = 3'd2,
		REG_INV_STEP_X = 3'd3,
		REG_INV_STEP_Y = 3'd4,
		REG_INV_STEP_Z = 3'd5,
		REG_SCALE      = 3'd6
	} tfmi_reg_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} tfmi_op_t;

	typedef struct packed {
		tfmi_op_t                        op;
		logic                            in_range;
		logic [ADDR_W-1:0]               addr;
		logic [AXES-1:0][FRAC_W-1:0]     frac;
		logic [AXES-1:0][SAMPLE_W-1:0]   sample;
	} tfmi_item_t;

	typedef struct packed {
		logic s1_full;
		logic s2_full;
	} tfmi_front_st_t;

	// a*(1-f) + b*f with f in Q0.16, exact
	function automatic logic signed [LERP_W-1:0] lerp(input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b, input logic [FRAC_W-1:0] f);
		logic signed [17:0] w1;
		logic signed [17:0] w0;
		w1 = signed'({2'b00, f});
		w0 = 18'sd65536 - w1;
		return LERP_W'(a) * LERP_W'(w0) + LERP_W'(b) * LERP_W'(w1);
	endfunction

	// round half up, drop 16 fraction bits
	function automatic logic signed [ACC_W-1:0] rnd16(input logic signed [LERP_W-1:0] x);
		logic signed [LERP_W-1:0] t;
		t = x + LERP_W'(32768);
		return ACC_W'(t >>> 16);
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tfmi_front.sv -----
// Front end: position offset, coordinate multiply, cell classification and address.
`default_nettype none
module tfmi_front #(
	parameter int GRID_X = tfmi_pkg::GRID_DEF,
	parameter int GRID_Y = tfmi_pkg::GRID_DEF,
	parameter int GRID_Z = tfmi_pkg::GRID_DEF
) (
	input  wire logic                                               clk,
	input  wire logic                                               arst_n,
	input  wire logic                                               accept,
	input  wire logic                                               opcode,
	input  wire logic [tfmi_pkg::ADDR_W-1:0]                        sample_index,
	input  wire logic [tfmi_pkg::AXES-1:0][tfmi_pkg::SAMPLE_W-1:0]  sample,
	input  wire logic [tfmi_pkg::AXES-1:0][tfmi_pkg::POS_W-1:0]     pos,
	input  wire logic [tfmi_pkg::AXES-1:0][tfmi_pkg::POS_W-1:0]     origin,
	input  wire logic [tfmi_pkg::AXES-1:0][tfmi_pkg::POS_W-1:0]     inv_step,
	output logic                                                    push,
	output tfmi_pkg::tfmi_item_t                                    push_item,
	output tfmi_pkg::tfmi_front_st_t                                st
);
	import tfmi_pkg::*;

	localparam logic [ADDR_W-1:0] DY = ADDR_W'(GRID_X);
	localparam logic [ADDR_W-1:0] DZ = ADDR_W'(GRID_X * GRID_Y);
	localparam logic [CELL_W-1:0] LIM_X = CELL_W'(GRID_X - 1);
	localparam logic [CELL_W-1:0] LIM_Y = CELL_W'(GRID_Y - 1);
	localparam logic [CELL_W-1:0] LIM_Z = CELL_W'(GRID_Z - 1);

	logic signed [POS_W:0]              d [AXES];
	logic                               v_s1;
	logic                               op_s1;
	logic [ADDR_W-1:0]                  idx_s1;
	logic [AXES-1:0][SAMPLE_W-1:0]      smp_s1;
	logic [AXES-1:0]                    neg_s1;
	logic [AXES-1:0][POS_W-1:0]         mag_s1;
	logic                               v_s2;
	logic                               op_s2;
	logic [ADDR_W-1:0]                  idx_s2;
	logic [AXES-1:0][SAMPLE_W-1:0]      smp_s2;
	logic [AXES-1:0]                    out_s2;
	logic [AXES-1:0][2*POS_W-1:0]       p_s2;
	logic [AXES-1:0][CELL_W-1:0]        cell_ix;
	logic [AXES-1:0][CELL_W-1:0]        lim;
	logic                               inr;
	logic [ADDR_W-1:0]                  base;

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			d[a] = (POS_W+1)'($signed(pos[a])) - (POS_W+1)'($signed(origin[a]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= opcode;
			idx_s1 <= sample_index;
			smp_s1 <= sample;
			for (int a = 0; a < AXES; a++) begin
				neg_s1[a] <= d[a][POS_W];
				mag_s1[a] <= d[a][POS_W-1:0];
			end
		end
		if (v_s1) begin
			op_s2  <= op_s1;
			idx_s2 <= idx_s1;
			smp_s2 <= smp_s1;
			for (int a = 0; a < AXES; a++) begin
				out_s2[a] <= neg_s1[a] && (inv_step[a] != '0);
				p_s2[a]   <= neg_s1[a] ? '0 :
					(2*POS_W)'(mag_s1[a]) * (2*POS_W)'(inv_step[a]);
			end
		end
	end

	// cell index is the Q.40 integer part, weight the next 16 bits
	always_comb begin
		lim = {LIM_Z, LIM_Y, LIM_X};
		inr = 1'b1;
		for (int a = 0; a < AXES; a++) begin
			cell_ix[a] = p_s2[a][2*POS_W-1:40];
			if (out_s2[a] || (cell_ix[a] >= lim[a])) begin
				inr = 1'b0;
			end
		end
		base = ADDR_W'(cell_ix[0][7:0]) + DY * ADDR_W'(cell_ix[1][7:0])
			+ DZ * ADDR_W'(cell_ix[2][7:0]);
	end

	always_comb begin
		push               = v_s2;
		push_item.op       = tfmi_op_t'(op_s2);
		push_item.in_range = (op_s2 == OP_QUERY) && inr;
		push_item.addr     = (op_s2 == OP_QUERY) ? base : idx_s2;
		for (int a = 0; a < AXES; a++) begin
			push_item.frac[a] = p_s2[a][39:24];
		end
		push_item.sample   = smp_s2;
		st.s1_full         = v_s1;
		st.s2_full         = v_s2;
	end

endmodule
`default_nettype wire

// ----- hw/rtl/tfmi_queue.sv -----
// Short item queue between front end and back end; drained one item a cycle.
`default_nettype none
module tfmi_queue (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	input  wire tfmi_pkg::tfmi_item_t           push_item,
	output logic                                pop_valid,
	output tfmi_pkg::tfmi_item_t                pop_item,
	output logic [tfmi_pkg::CNT_W-1:0]          count
);
	import tfmi_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);

	tfmi_item_t         ent_q [QDEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign pop_valid = (count_q != '0);
	assign pop_item  = ent_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop_valid) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop_valid);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/tfmi_back.sv -----
// Back end: sample store, corner reads, three-level interpolation, scale and saturate.
`default_nettype none
module tfmi_back #(
	parameter int GRID_X = tfmi_pkg::GRID_DEF,
	parameter int GRID_Y = tfmi_pkg::GRID_DEF
) (
	input  wire logic                                           clk,
	input  wire logic                                           arst_n,
	input  wire logic                                           pop_valid,
	input  wire tfmi_pkg::tfmi_item_t                           item,
	input  wire logic [tfmi_pkg::SCALE_W-1:0]                   field_scale,
	output logic                                                result_valid,
	output logic [tfmi_pkg::AXES-1:0][tfmi_pkg::OUT_W-1:0]      field,
	output logic                                                in_range
);
	import tfmi_pkg::*;

	function automatic logic [ADDR_W-1:0] corner_off(input int k);
		return ADDR_W'(((k & 1) != 0 ? 1 : 0) + ((k & 2) != 0 ? GRID_X : 0)
			+ ((k & 4) != 0 ? GRID_X * GRID_Y : 0));
	endfunction

	logic                               rd_en;
	logic                               wr_en;
	logic [ADDR_W-1:0]                  caddr [CORNERS];
	logic [AXES-1:0][SAMPLE_W-1:0]      rd_s1 [CORNERS];
	logic                               vq_s1, vq_s2, vq_s3, vq_s4, vq_s5;
	logic                               inr_s1, inr_s2, inr_s3, inr_s4, inr_s5;
	logic [AXES-1:0][FRAC_W-1:0]        frac_s1;
	logic [FRAC_W-1:0]                  fy_s2, fz_s2, fz_s3;
	logic signed [ACC_W-1:0]            a_s2 [AXES][4];
	logic signed [ACC_W-1:0]            c_s3 [AXES][2];
	logic signed [ACC_W-1:0]            v_s4 [AXES];
	logic signed [PROD_W-1:0]           prod_s5 [AXES];
	logic signed [SCALE_W:0]            nscale;
	logic signed [PROD_W-1:0]           t_rnd [AXES];
	logic signed [PROD_W-33:0]          r_rnd [AXES];
	logic [AXES-1:0][OUT_W-1:0]         sat;

	assign rd_en = pop_valid && (item.op == OP_QUERY);
	assign wr_en = pop_valid && (item.op == OP_WRITE);

	always_comb begin
		for (int k = 0; k < CORNERS; k++) begin
			caddr[k] = item.addr + corner_off(k);
		end
	end

	// each copy holds the whole store, giving two corner reads a cycle
	for (genvar m = 0; m < RD_COPIES; m++) begin : g_copy
		logic [AXES-1:0][SAMPLE_W-1:0] ram [STORE_DEPTH];
		logic [AXES-1:0][SAMPLE_W-1:0] r0_s1;
		logic [AXES-1:0][SAMPLE_W-1:0] r1_s1;

		always_ff @(posedge clk) begin
			if (wr_en) begin
				ram[item.addr] <= item.sample;
			end
			if (rd_en) begin
				r0_s1 <= ram[caddr[2*m]];
				r1_s1 <= ram[caddr[2*m+1]];
			end
		end

		assign rd_s1[2*m]   = r0_s1;
		assign rd_s1[2*m+1] = r1_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vq_s1        <= 1'b0;
			vq_s2        <= 1'b0;
			vq_s3        <= 1'b0;
			vq_s4        <= 1'b0;
			vq_s5        <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			vq_s1        <= rd_en;
			vq_s2        <= vq_s1;
			vq_s3        <= vq_s2;
			vq_s4        <= vq_s3;
			vq_s5        <= vq_s4;
			result_valid <= vq_s5;
		end
	end

	assign nscale = -(SCALE_W+1)'($signed(field_scale));

	always_ff @(posedge clk) begin
		if (rd_en) begin
			inr_s1  <= item.in_range;
			frac_s1 <= item.frac;
		end
		if (vq_s1) begin
			inr_s2 <= inr_s1;
			fy_s2  <= frac_s1[1];
			fz_s2  <= frac_s1[2];
			for (int c = 0; c < AXES; c++) begin
				for (int j = 0; j < 4; j++) begin
					a_s2[c][j] <= ACC_W'(lerp(ACC_W'($signed(rd_s1[2*j][c])),
						ACC_W'($signed(rd_s1[2*j+1][c])), frac_s1[0]));
				end
			end
		end
		if (vq_s2) begin
			inr_s3 <= inr_s2;
			fz_s3  <= fz_s2;
			for (int c = 0; c < AXES; c++) begin
				for (int k = 0; k < 2; k++) begin
					c_s3[c][k] <= rnd16(lerp(a_s2[c][2*k], a_s2[c][2*k+1], fy_s2));
				end
			end
		end
		if (vq_s3) begin
			inr_s4 <= inr_s3;
			for (int c = 0; c < AXES; c++) begin
				v_s4[c] <= rnd16(lerp(c_s3[c][0], c_s3[c][1], fz_s3));
			end
		end
		if (vq_s4) begin
			inr_s5 <= inr_s4;
			for (int c = 0; c < AXES; c++) begin
				prod_s5[c] <= PROD_W'(v_s4[c]) * PROD_W'(nscale);
			end
		end
		if (vq_s5) begin
			in_range <= inr_s5;
			field    <= inr_s5 ? sat : '0;
		end
	end

	// Q.32 product, round half up to integer, clamp to 32 bits
	always_comb begin
		for (int c = 0; c < AXES; c++) begin
			t_rnd[c] = prod_s5[c] + PROD_W'(64'sd2147483648);
			r_rnd[c] = (PROD_W-32)'(t_rnd[c] >>> 32);
			if (r_rnd[c] > (PROD_W-32)'(64'sd2147483647)) begin
				sat[c] = 32'h7FFF_FFFF;
			end else if (r_rnd[c] < -(PROD_W-32)'(64'sd2147483648)) begin
				sat[c] = 32'h8000_0000;
			end else begin
				sat[c] = r_rnd[c][OUT_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/trilinear_field_map_interp_unit.sv -----
// Top level of the trilinear field map interpolator: config registers, front, queue, back.
`default_nettype none
// Takes one item per clock: start with busy low hands over either a sample write
// (opcode 0) or a field query (opcode 1). A write produces no result; a query
// produces exactly one result, shown on field_x/y/z and in_range for a single cycle
// under result_valid, in item order. The receiver cannot hold results off, and none
// is needed: the back end drains the queue every cycle, so busy stays low under any
// start pattern. Latency is set by the front end (offset, 32x32 coordinate multiply,
// cell classification), the queue stage, and the back end (store read, x, y and z
// blends, scale multiply, round and clamp). All eight corners are read in one cycle
// from four full copies of the sample store, each with two read ports; every write
// goes to all copies. The store has no reset and no clearing pass: a query that
// touches an entry never written returns undefined field values. Config writes take
// effect at once and are to be made only while no item is in flight.
module trilinear_field_map_interp_unit #(
	parameter int GRID_X = tfmi_pkg::GRID_DEF,
	parameter int GRID_Y = tfmi_pkg::GRID_DEF,
	parameter int GRID_Z = tfmi_pkg::GRID_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic                                   opcode,
	input  wire logic [tfmi_pkg::ADDR_W-1:0]            sample_index,
	input  wire logic signed [tfmi_pkg::SAMPLE_W-1:0]   sample_bx,
	input  wire logic signed [tfmi_pkg::SAMPLE_W-1:0]   sample_by,
	input  wire logic signed [tfmi_pkg::SAMPLE_W-1:0]   sample_bz,
	input  wire logic signed [tfmi_pkg::POS_W-1:0]      pos_x,
	input  wire logic signed [tfmi_pkg::POS_W-1:0]      pos_y,
	input  wire logic signed [tfmi_pkg::POS_W-1:0]      pos_z,
	input  wire logic                                   cfg_we,
	input  wire logic [2:0]                             cfg_index,
	input  wire logic [tfmi_pkg::POS_W-1:0]             cfg_data,
	output logic                                        result_valid,
	output logic signed [tfmi_pkg::OUT_W-1:0]           field_x,
	output logic signed [tfmi_pkg::OUT_W-1:0]           field_y,
	output logic signed [tfmi_pkg::OUT_W-1:0]           field_z,
	output logic                                        in_range
);
	import tfmi_pkg::*;

	// config registers
	logic [POS_W-1:0]               origin_x_q, origin_y_q, origin_z_q;
	logic [POS_W-1:0]               inv_step_x_q, inv_step_y_q, inv_step_z_q;
	logic [SCALE_W-1:0]             field_scale_q;

	logic                           accept;
	logic                           q_push;
	tfmi_item_t                     q_push_item;
	tfmi_front_st_t                 front_st;
	logic                           q_pop_valid;
	tfmi_item_t                     q_pop_item;
	logic [CNT_W-1:0]               q_count;
	logic [CNT_W:0]                 occ;
	logic [AXES-1:0][OUT_W-1:0]     field;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			origin_z_q    <= '0;
			inv_step_x_q  <= 32'd16777216;
			inv_step_y_q  <= 32'd16777216;
			inv_step_z_q  <= 32'd16777216;
			field_scale_q <= 24'd65536;
		end else if (cfg_we) begin
			unique case (tfmi_reg_t'(cfg_index))
				REG_ORIGIN_X:   origin_x_q    <= cfg_data;
				REG_ORIGIN_Y:   origin_y_q    <= cfg_data;
				REG_ORIGIN_Z:   origin_z_q    <= cfg_data;
				REG_INV_STEP_X: inv_step_x_q  <= cfg_data;
				REG_INV_STEP_Y: inv_step_y_q  <= cfg_data;
				REG_INV_STEP_Z: inv_step_z_q  <= cfg_data;
				REG_SCALE:      field_scale_q <= cfg_data[SCALE_W-1:0];
				default: begin
					// index past the register list: write dropped
				end
			endcase
		end
	end

	// room in the queue for everything already in the front end plus one more item
	assign occ    = (CNT_W+1)'(q_count) + (CNT_W+1)'(front_st.s1_full)
		+ (CNT_W+1)'(front_st.s2_full);
	assign busy   = (occ >= (CNT_W+1)'(QDEPTH));
	assign accept = start && !busy;

	tfmi_front #(
		.GRID_X(GRID_X),
		.GRID_Y(GRID_Y),
		.GRID_Z(GRID_Z)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.opcode      (opcode),
		.sample_index(sample_index),
		.sample      ({sample_bz, sample_by, sample_bx}),
		.pos         ({pos_z, pos_y, pos_x}),
		.origin      ({origin_z_q, origin_y_q, origin_x_q}),
		.inv_step    ({inv_step_z_q, inv_step_y_q, inv_step_x_q}),
		.push        (q_push),
		.push_item   (q_push_item),
		.st          (front_st)
	);

	tfmi_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(q_push_item),
		.pop_valid(q_pop_valid),
		.pop_item (q_pop_item),
		.count    (q_count)
	);

	tfmi_back #(
		.GRID_X(GRID_X),
		.GRID_Y(GRID_Y)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (q_pop_valid),
		.item        (q_pop_item),
		.field_scale (field_scale_q),
		.result_valid(result_valid),
		.field       (field),
		.in_range    (in_range)
	);

	assign field_x = field[0];
	assign field_y = field[1];
	assign field_z = field[2];

	// checks
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_count < CNT_W'(QDEPTH)))
		else $error("item pushed into a full queue");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(q_count == '0) |-> !busy)
		else $error("busy raised with an empty queue");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !in_range) |-> (field_x == '0 && field_y == '0 && field_z == '0))
		else $error("point outside the grid gave a non-zero field");

endmodule
`default_nettype wire

// ----- sim/trilinear_field_map_interp_unit_tb.sv -----
// Self-checking testbench for the trilinear field map interpolator: sample writes and field queries.
`default_nettype none
module trilinear_field_map_interp_unit_tb;
	import tfmi_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int GX = 32;
	localparam int GY = 32;
	localparam int GZ = 32;
	localparam logic [2:0] REG_SPARE = 3'd7;	// beyond the register list, must be ignored
	localparam int DRAIN_CYCLES = 20;	// margin past the block latency
	localparam int STALL_LIMIT = 5000;
	localparam logic [14:0] ADDR_MASK = 15'h7FFF;

	typedef struct {
		tfmi_op_t                 op;
		logic [ADDR_W-1:0]        addr;
		logic signed [23:0]       b [3];
		logic signed [31:0]       pos [3];
	} op_item_t;

	typedef struct {
		logic signed [31:0] f [3];
		logic               inr;
	} field_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start;
	logic busy;
	logic opcode;
	logic [ADDR_W-1:0] sample_index;
	logic signed [SAMPLE_W-1:0] sample_bx, sample_by, sample_bz;
	logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = 3'd0;
	logic [POS_W-1:0] cfg_data = '0;
	logic result_valid;
	logic signed [OUT_W-1:0] field_x, field_y, field_z;
	logic in_range;

	trilinear_field_map_interp_unit #(.GRID_X(GX), .GRID_Y(GY), .GRID_Z(GZ)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .opcode(opcode),
		.sample_index(sample_index), .sample_bx(sample_bx), .sample_by(sample_by),
		.sample_bz(sample_bz), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_valid(result_valid), .field_x(field_x), .field_y(field_y),
		.field_z(field_z), .in_range(in_range)
	);

	always #5 clk = ~clk;

	// shadow of the block: config registers and the three sample stores
	longint      grid_org [3];
	logic [63:0] grid_inv [3];
	longint      fscale;
	int          sample_store [3][STORE_DEPTH];
	bit          gen_written [STORE_DEPTH];	// tracked at generation time, queue keeps order

	op_item_t   pending_items [$];
	field_res_t expected_fields [$];
	op_item_t   cur_item;
	int gap_left;
	int gap_pct;
	int mismatches;
	int n_writes, n_queries, n_in_range, n_checked, n_cfg;
	int n_gen;
	int stall_cycles;

	// Round half up: floor(x / 2^s + 1/2)
	function automatic longint round_half_up(longint x, int s);
		return (x + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint blend(longint a, longint b, longint w);
		return a * (65536 - w) + b * w;
	endfunction

	// Cell index and Q0.16 weight along one axis; 0 when the point is off the grid
	function automatic bit locate_axis(logic signed [31:0] p, int ax, int size,
		output int cell_idx, output longint w);
		longint d;
		logic [63:0] prod;
		logic [63:0] cell_hi;
		cell_idx = 0;
		w = 0;
		d = longint'(p) - grid_org[ax];
		if (d < 0) begin
			if (grid_inv[ax] != 0)
				return 1'b0;
			prod = '0;
		end else begin
			prod = 64'(d) * grid_inv[ax];
		end
		cell_hi = prod >> 40;
		if (cell_hi >= 64'(size - 1))
			return 1'b0;
		cell_idx = int'(cell_hi);
		w = longint'(prod[39:24]);
		return 1'b1;
	endfunction

	// Base address of the cell holding a query point; -1 when outside
	function automatic int cell_base(op_item_t it, output longint w [3]);
		int ix, iy, iz;
		if (!locate_axis(it.pos[0], 0, GX, ix, w[0]) ||
			!locate_axis(it.pos[1], 1, GY, iy, w[1]) ||
			!locate_axis(it.pos[2], 2, GZ, iz, w[2]))
			return -1;
		return ix + GX * iy + GX * GY * iz;
	endfunction

	function automatic logic [14:0] corner_addr(int base, int k);
		int off;
		off = (k[0] ? 1 : 0) + (k[1] ? GX : 0) + (k[2] ? GX * GY : 0);
		return 15'(base + off) & ADDR_MASK;
	endfunction

	// x blend, then y, then z, then scale by the negated factor and clamp
	function automatic logic signed [31:0] field_component(int c, int base, longint w [3]);
		longint zc [2];
		longint a0, a1, r;
		for (int k = 0; k < 2; k++) begin
			a0 = blend(sample_store[c][corner_addr(base, 4 * k)],
				sample_store[c][corner_addr(base, 4 * k + 1)], w[0]);
			a1 = blend(sample_store[c][corner_addr(base, 4 * k + 2)],
				sample_store[c][corner_addr(base, 4 * k + 3)], w[0]);
			zc[k] = round_half_up(blend(a0, a1, w[1]), 16);
		end
		r = round_half_up(blend(zc[0], zc[1], w[2]), 16);
		r = round_half_up(r * (-fscale), 32);
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		return r[31:0];
	endfunction

	// Apply one accepted item to the shadow; queries queue their expected field
	function automatic void fold_item(op_item_t it);
		field_res_t res;
		longint w [3];
		int base;
		if (it.op == OP_WRITE) begin
			for (int c = 0; c < 3; c++)
				sample_store[c][it.addr] = it.b[c];
			n_writes++;
			return;
		end
		n_queries++;
		base = cell_base(it, w);
		res.inr = (base >= 0);
		for (int c = 0; c < 3; c++)
			res.f[c] = res.inr ? field_component(c, base, w) : 32'sd0;
		if (res.inr)
			n_in_range++;
		expected_fields.push_back(res);
	endfunction

	// Driver: one item per accepted start, random idle bursts in between
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			opcode <= OP_WRITE;
			sample_index <= '0;
			sample_bx <= '0;
			sample_by <= '0;
			sample_bz <= '0;
			pos_x <= '0;
			pos_y <= '0;
			pos_z <= '0;
			gap_left = 0;
		end else begin
			if (start && !busy)
				fold_item(cur_item);
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_items.size() > 0) begin
					cur_item = pending_items.pop_front();
					opcode <= cur_item.op;
					sample_index <= cur_item.addr;
					sample_bx <= cur_item.b[0];
					sample_by <= cur_item.b[1];
					sample_bz <= cur_item.b[2];
					pos_x <= cur_item.pos[0];
					pos_y <= cur_item.pos[1];
					pos_z <= cur_item.pos[2];
					start <= 1'b1;
					if ($urandom_range(0, 99) < gap_pct)
						gap_left = $urandom_range(1, 13);
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: results last one cycle, compare against the oldest expectation
	always @(posedge clk) begin
		field_res_t exp_r;
		if (arst_n && result_valid) begin
			if (expected_fields.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result %0d %0d %0d in_range=%0b",
						field_x, field_y, field_z, in_range);
			end else begin
				exp_r = expected_fields.pop_front();
				n_checked++;
				if (exp_r.f[0] !== field_x || exp_r.f[1] !== field_y ||
					exp_r.f[2] !== field_z || exp_r.inr !== in_range) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: field exp %0d %0d %0d ir=%0b got %0d %0d %0d ir=%0b",
							exp_r.f[0], exp_r.f[1], exp_r.f[2], exp_r.inr,
							field_x, field_y, field_z, in_range);
				end
			end
		end
	end

	// Watchdog: cycles with neither an accepted item nor a result
	always @(posedge clk) begin
		if ((start && !busy) || result_valid)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout: no progress for %0d cycles", STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Register write, block idle; shadow copy updated alongside
	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_ORIGIN_X:   grid_org[0] = longint'(signed'(val));
			REG_ORIGIN_Y:   grid_org[1] = longint'(signed'(val));
			REG_ORIGIN_Z:   grid_org[2] = longint'(signed'(val));
			REG_INV_STEP_X: grid_inv[0] = 64'(val);
			REG_INV_STEP_Y: grid_inv[1] = 64'(val);
			REG_INV_STEP_Z: grid_inv[2] = 64'(val);
			REG_SCALE:      fscale = longint'(signed'(val[23:0]));
			default: ;
		endcase
		n_cfg++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
		logic [31:0] sx, logic [31:0] sy, logic [31:0] sz, logic [31:0] sc);
		reg_write(REG_ORIGIN_X, ox);
		reg_write(REG_ORIGIN_Y, oy);
		reg_write(REG_ORIGIN_Z, oz);
		reg_write(REG_INV_STEP_X, sx);
		reg_write(REG_INV_STEP_Y, sy);
		reg_write(REG_INV_STEP_Z, sz);
		reg_write(REG_SCALE, sc);
	endtask

	// Wait until every item is in and every result out, then let the pipe drain
	task automatic drain;
		while (pending_items.size() > 0 || start || expected_fields.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [23:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic push_write(logic [14:0] a);
		op_item_t it;
		it.op = OP_WRITE;
		it.addr = a;
		for (int c = 0; c < 3; c++)
			it.b[c] = rand_sample();
		it.pos[0] = 32'($urandom);
		it.pos[1] = 32'($urandom);
		it.pos[2] = 32'($urandom);
		gen_written[a] = 1'b1;
		n_gen++;
		@(negedge clk);
		pending_items.push_back(it);
	endtask

	// Queue a query, first writing any corner of its cell that has never been written
	task automatic push_query(logic signed [31:0] px, logic signed [31:0] py,
		logic signed [31:0] pz);
		op_item_t it;
		longint w [3];
		int base;
		it.op = OP_QUERY;
		it.addr = 15'($urandom);
		for (int c = 0; c < 3; c++)
			it.b[c] = 24'($urandom);
		it.pos[0] = px;
		it.pos[1] = py;
		it.pos[2] = pz;
		base = cell_base(it, w);
		if (base >= 0)
			for (int k = 0; k < 8; k++)
				if (!gen_written[corner_addr(base, k)])
					push_write(corner_addr(base, k));
		n_gen++;
		@(negedge clk);
		pending_items.push_back(it);
	endtask

	// Position along one axis that mostly lands inside the grid
	function automatic logic signed [31:0] aim_axis(int ax, int size);
		logic [63:0] lim, d;
		if (grid_inv[ax] == 0)
			return 32'($urandom);
		lim = ((64'(size - 1)) << 40) / grid_inv[ax];
		if (lim > 64'hFFFF_FFFF)
			lim = 64'hFFFF_FFFF;
		d = {32'($urandom), 32'($urandom)} % (lim + 1);
		return 32'(grid_org[ax] + longint'(d));
	endfunction

	// Generates about count items in all, corner fills included
	task automatic random_items(int count);
		int stop_at;
		stop_at = n_gen + count;
		while (n_gen < stop_at) begin
			case ($urandom_range(0, 9))
				0, 1, 2: push_write(15'($urandom));
				3: push_query(32'($urandom), 32'($urandom), 32'($urandom));
				4: push_query(aim_axis(0, GX), aim_axis(1, GY), 32'($urandom));
				default: push_query(aim_axis(0, GX), aim_axis(1, GY), aim_axis(2, GZ));
			endcase
		end
	endtask

	initial begin
		grid_org = '{0, 0, 0};
		grid_inv = '{64'd16777216, 64'd16777216, 64'd16777216};
		fscale = 65536;
		mismatches = 0;
		gap_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset config, extreme samples, cell corners and grid edges
		gap_pct = 30;
		push_write(15'd0);
		push_write(15'h7FFF);
		push_query(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);	// exact first corner
		push_query(32'sh0000_FFFF, 32'sh0000_FFFF, 32'sh0000_FFFF);	// weight at maximum
		push_query(32'sh001E_0000, 32'sh001E_0000, 32'sh001E_0000);	// last full cell
		push_query(32'sh001E_FFFF, 32'sh001E_8000, 32'sh001E_0001);
		push_query(32'sh001F_0000, 32'sh0000_0000, 32'sh0000_0000);	// at size minus one
		push_query(32'sh0000_0000, 32'sh001F_0000, 32'sh0000_0000);
		push_query(32'sh0000_0000, 32'sh0000_0000, 32'sh001F_0000);
		push_query(32'shFFFF_FFFF, 32'sh0000_0000, 32'sh0000_0000);	// negative offset
		push_query(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
		push_query(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		drain();

		// Negative origin, mixed spacings, negative scale; spare index ignored
		set_grid(32'hFFF0_0000, 32'h0004_8000, 32'hFFFF_0000,
			32'h0080_0000, 32'h0200_0000, 32'h0100_0000, 32'hFF8000);
		reg_write(REG_SPARE, 32'hFFFF_FFFF);
		gap_pct = 25;
		random_items(180);
		drain();

		// Extremes: zero step (negative offsets fold to zero), finest step, largest scales
		set_grid(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
			32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFFFF);
		push_query(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000);
		push_query(32'sh0000_0000, 32'sh8000_1000, 32'sh7FFF_FFFF);
		random_items(100);
		drain();
		set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000,
			32'hFFFF_FFFF, 32'h0000_0000, 32'h0010_0000, 32'h800000);
		random_items(100);
		drain();

		// Random config, then a final stretch with no idling
		set_grid($urandom_range(0, 32'h00FF_FFFF), 32'($urandom), $urandom_range(0, 32'h0000_FFFF),
			$urandom_range(32'h0040_0000, 32'h0400_0000), 32'($urandom),
			$urandom_range(32'h0040_0000, 32'h0400_0000), 32'($urandom));
		gap_pct = 20;
		random_items(120);
		drain();
		gap_pct = 0;
		random_items(100);
		drain();

		$display("Covered %0d sample writes and %0d queries (%0d inside the grid), %0d checked",
			n_writes, n_queries, n_in_range, n_checked);
		$display("over %0d register writes including zero and full-scale steps", n_cfg);
		if (mismatches == 0 && expected_fields.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, expected_fields.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
`default_nettype wire
